### design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, widths and codes for the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 128;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 1'b1;

    localparam logic [3:0] ST_BAD_HW     = 4'd0;
    localparam logic [3:0] ST_BAD_PROTO  = 4'd1;
    localparam logic [3:0] ST_NOT_OURS   = 4'd2;
    localparam logic [3:0] ST_FULL       = 4'd3;
    localparam logic [3:0] ST_BAD_OP     = 4'd4;
    localparam logic [3:0] ST_REPLIED    = 4'd5;
    localparam logic [3:0] ST_REPLY_SEEN = 4'd6;
    localparam logic [3:0] ST_HIT        = 4'd7;
    localparam logic [3:0] ST_MISS       = 4'd8;

    typedef struct packed {
        logic        req_type;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] lookup_ip;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_dest_ip;
        logic [47:0] found_mac;
    } result_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

endpackage

### design/arpc_cache_mem.sv
// ----------------------------------------------------------------------------
// arpc_cache_mem
// Address cache storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_cache_mem (
    input  logic              aclk,
    input  arpc_pkg::mem_req_t req,
    output arpc_pkg::entry_t  rd_data
);
    import arpc_pkg::*;

    entry_t mem [CACHE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: scans the cache one entry per cycle, refreshes or appends an
// ARP packet's sender entry, and forms the result item in an output register.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  arpc_pkg::item_t            in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output arpc_pkg::result_t          out_item,
    input  logic [31:0]                local_ip,
    output arpc_pkg::mem_req_t         mem_req,
    input  arpc_pkg::entry_t           mem_rd_data,
    output logic [arpc_pkg::CNT_W-1:0] fill_cnt
);
    import arpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [CNT_W-1:0]  iss_idx_reg, iss_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [47:0]       hit_mac_reg, hit_mac_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              out_vld_reg, out_vld_next;

    logic [31:0] key_ip;
    logic        hit;
    logic        issue;

    assign key_ip = item_reg.req_type ? item_reg.lookup_ip : item_reg.sender_ip;
    assign hit    = (state_reg == S_SCAN) && pend_reg && (mem_rd_data.ip == key_ip);
    assign issue  = (state_reg == S_SCAN) && !hit && (iss_idx_reg < fill_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;
    assign fill_cnt  = fill_reg;

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        iss_idx_next  = iss_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        hit_mac_next  = hit_mac_reg;
        fill_next     = fill_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;

        mem_req.rd_en   = issue;
        mem_req.rd_addr = iss_idx_reg[IDX_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = hit_idx_reg;
        mem_req.wr_data = '{ip: item_reg.sender_ip, mac: item_reg.sender_mac};

        if (out_vld_reg && out_ready) begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next    = in_item;
                    iss_idx_next = '0;
                    pend_next    = 1'b0;
                    found_next   = 1'b0;
                    res_next     = '0;
                    if (!in_item.req_type && (in_item.hw_type != HW_ETHERNET)) begin
                        res_next.status = ST_BAD_HW;
                        state_next      = S_RESULT;
                    end else if (!in_item.req_type && (in_item.proto_type != PROTO_IPV4)) begin
                        res_next.status = ST_BAD_PROTO;
                        state_next      = S_RESULT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    hit_mac_next = mem_rd_data.mac;
                    pend_next    = 1'b0;
                    state_next   = S_DECIDE;
                end else if (issue) begin
                    pend_next     = 1'b1;
                    pend_idx_next = iss_idx_reg[IDX_W-1:0];
                    iss_idx_next  = iss_idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                res_next   = '0;
                state_next = S_RESULT;
                if (item_reg.req_type) begin
                    if (found_reg) begin
                        res_next.status    = ST_HIT;
                        res_next.found_mac = hit_mac_reg;
                    end else begin
                        res_next.status = ST_MISS;
                    end
                end else begin
                    mem_req.wr_en = found_reg;
                    if (item_reg.target_ip != local_ip) begin
                        res_next.status = ST_NOT_OURS;
                    end else if (!found_reg && (fill_reg >= CNT_W'(CACHE_ENTRIES))) begin
                        res_next.status = ST_FULL;
                    end else begin
                        if (!found_reg) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = fill_reg[IDX_W-1:0];
                            fill_next       = fill_reg + 1'b1;
                        end
                        priority if (item_reg.arp_op == OP_REQUEST) begin
                            res_next.status         = ST_REPLIED;
                            res_next.reply_dest_mac = item_reg.sender_mac;
                            res_next.reply_dest_ip  = item_reg.sender_ip;
                        end else if (item_reg.arp_op == OP_REPLY) begin
                            res_next.status = ST_REPLY_SEEN;
                        end else begin
                            res_next.status = ST_BAD_OP;
                        end
                    end
                end
            end
            S_RESULT: begin
                if (!out_vld_reg || out_ready) begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            fill_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            out_vld_reg <= out_vld_next;
        end
        item_reg     <= item_next;
        iss_idx_reg  <= iss_idx_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        hit_idx_reg  <= hit_idx_next;
        hit_mac_reg  <= hit_mac_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

### design/arp_responder_with_cache_unit.sv
// ----------------------------------------------------------------------------
// arp_responder_with_cache_unit
// ARP responder for IPv4 over Ethernet with a bounded address cache.
//
//  channel   dir   handshake           payload
//  s_        in    s_tvalid/s_tready   s_tuser req_type, s_tdata packet fields
//  m_        out   m_tvalid/m_tready   m_tuser status, m_tdata reply fields
//  cfg_      in    cfg_valid/cfg_ready cfg_index, cfg_data
//
// The cache memory is scanned one entry per cycle through its single read
// port. ARP packets with bad hardware or protocol types skip the scan.
// Reset clears the fill count, so the cache starts empty with no sweep.
// A result waiting in the output register holds the sequencer until taken.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // hw_type, proto_type, arp_op, sender_mac, sender_ip, target_ip, lookup_ip
    input  logic [arpc_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // reply_dest_mac, reply_dest_ip, found_mac
    output logic [arpc_pkg::M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [3:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import arpc_pkg::*;

    logic [31:0]      local_ip_reg;
    logic [47:0]      local_mac_reg;
    item_t            in_item;
    result_t          out_item;
    mem_req_t         mem_req;
    entry_t           mem_rd_data;
    logic [CNT_W-1:0] fill_cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LOCAL_IP:  local_ip_reg  <= cfg_data[31:0];
                REG_LOCAL_MAC: local_mac_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.req_type   = s_tuser;
    assign in_item.hw_type    = s_tdata[15:0];
    assign in_item.proto_type = s_tdata[31:16];
    assign in_item.arp_op     = s_tdata[47:32];
    assign in_item.sender_mac = s_tdata[95:48];
    assign in_item.sender_ip  = s_tdata[127:96];
    assign in_item.target_ip  = s_tdata[159:128];
    assign in_item.lookup_ip  = s_tdata[191:160];

    assign m_tuser = out_item.status;
    assign m_tdata = {out_item.found_mac, out_item.reply_dest_ip, out_item.reply_dest_mac};

    arpc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (out_item),
        .local_ip    (local_ip_reg),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .fill_cnt    (fill_cnt)
    );

    arpc_cache_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt <= CNT_W'(CACHE_ENTRIES))
        else $error("cache fill count beyond capacity");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (fill_cnt != $past(fill_cnt)) |->
            (fill_cnt == $past(fill_cnt) + 1'b1) && !mem_req.wr_en)
        else $error("cache fill count moved by more than one entry");

    a_reply_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_REPLIED) |-> (m_tdata[79:0] == '0))
        else $error("reply fields set on a result that is not a reply");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready) |=> $stable(local_ip_reg) && $stable(local_mac_reg))
        else $error("local address changed without a register write");

endmodule
